@@ hw/rtl/segisect_pkg.sv @@
// package: shared types and constants of the segment intersection block
`default_nettype none
package segisect_pkg;
	localparam int PORT_W     = 16;
	localparam int KIND_W     = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int DEN_EPS_W  = 34;
	localparam int PAR_EPS_W  = 16;
	localparam int CFG_DATA_W = 34;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE     = 3'd0,
		KIND_SHARED   = 3'd1,
		KIND_CROSS    = 3'd2,
		KIND_PARALLEL = 3'd3,
		KIND_DEGEN    = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEN_EPS   = 1'b0,
		CFG_PARAM_EPS = 1'b1
	} cfg_idx_t;
endpackage
`default_nettype wire

@@ hw/rtl/segment_intersection.sv @@
// top level: pipelined two-segment intersection test with point output
//
// One segment pair enters per cycle when the output is not stalled. Five front stages form
// differences, the six partial products, the cross products and their sign normalization,
// the tolerance products and the range compare; then a restoring divider spends one
// stage per quotient bit (COORD_WIDTH + 2 stages) on both coordinates at once, and a last
// stage adds, saturates and holds the result. Each stage moves on whenever the stage after
// it is empty or moving, so bubbles close up and a stall at the output backs up only as
// far as the pipeline is full. Configuration takes effect for items accepted after the
// write and must be written while the pipeline is empty.
`default_nettype none
module segment_intersection #(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic signed [segisect_pkg::PORT_W-1:0] p_x,
	input  wire logic signed [segisect_pkg::PORT_W-1:0] p_y,
	input  wire logic signed [segisect_pkg::PORT_W-1:0] p2_x,
	input  wire logic signed [segisect_pkg::PORT_W-1:0] p2_y,
	input  wire logic signed [segisect_pkg::PORT_W-1:0] q_x,
	input  wire logic signed [segisect_pkg::PORT_W-1:0] q_y,
	input  wire logic signed [segisect_pkg::PORT_W-1:0] q2_x,
	input  wire logic signed [segisect_pkg::PORT_W-1:0] q2_y,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic      hit,
	output logic [segisect_pkg::KIND_W-1:0] kind,
	output logic signed [segisect_pkg::PORT_W-1:0] cross_x,
	output logic signed [segisect_pkg::PORT_W-1:0] cross_y,
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	input  wire logic [segisect_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [segisect_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int CW   = COORD_WIDTH;
	localparam int DIFW = CW + 1;
	localparam int PRW  = 2 * DIFW;
	localparam int XW   = PRW + 1;
	localparam int EDW  = XW + segisect_pkg::PAR_EPS_W;
	localparam int CMPW = XW + 19;
	localparam int NW   = DIFW + XW;
	localparam int QW   = CW + 2;
	localparam int RW   = XW + 1;
	localparam int SW   = QW + 2;
	localparam int PW   = segisect_pkg::PORT_W;
	localparam int FRONT = 5;
	localparam int NS   = FRONT + QW + 1;

	localparam logic signed [SW-1:0] CMAX = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] CMIN = SW'(-(64'sd1 <<< (CW - 1)));

	typedef struct packed {
		logic                    done;
		segisect_pkg::kind_t     kind;
		logic signed [CW-1:0]    ex;
		logic signed [CW-1:0]    ey;
		logic signed [CW-1:0]    px;
		logic signed [CW-1:0]    py;
		logic                    negx;
		logic                    negy;
	} meta_t;

	function automatic logic [PW-1:0] to_port(input logic [CW-1:0] v);
		logic [CW+PW-1:0] w;
		w = {{PW{v[CW-1]}}, v};
		return w[PW-1:0];
	endfunction

	// configuration
	logic [segisect_pkg::DEN_EPS_W-1:0] den_eps_q;
	logic [segisect_pkg::PAR_EPS_W-1:0] par_eps_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_eps_q <= segisect_pkg::DEN_EPS_W'(1);
			par_eps_q <= segisect_pkg::PAR_EPS_W'(7);
		end else if (cfg_valid) begin
			unique case (segisect_pkg::cfg_idx_t'(cfg_index))
				segisect_pkg::CFG_DEN_EPS:   den_eps_q <= cfg_data[segisect_pkg::DEN_EPS_W-1:0];
				segisect_pkg::CFG_PARAM_EPS: par_eps_q <= cfg_data[segisect_pkg::PAR_EPS_W-1:0];
				default: ;
			endcase
		end
	end

	// stage flow control
	logic [NS-1:0] vld;
	logic [NS:0]   adv;
	logic [NS-1:0] vld_in;

	assign adv[NS] = out_ready;
	assign vld_in  = {vld[NS-2:0], in_valid};
	for (genvar k = 0; k < NS; k++) begin : g_adv
		assign adv[k] = ~vld[k] | adv[k+1];
	end
	assign in_ready  = adv[0];
	assign out_valid = vld[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (adv[k]) vld[k] <= vld_in[k];
			end
		end
	end

	// stage 1: endpoint tests and differences
	logic [PW-1:0]        raw [8];
	logic signed [CW-1:0] c [8];
	logic                 degen, sh1, sh2;
	meta_t                meta_c1;

	always_comb begin
		raw[0] = p_x;  raw[1] = p_y;  raw[2] = p2_x; raw[3] = p2_y;
		raw[4] = q_x;  raw[5] = q_y;  raw[6] = q2_x; raw[7] = q2_y;
		for (int i = 0; i < 8; i++) begin
			c[i] = CW'({{CW{1'b0}}, raw[i]});
		end
		degen = (c[0] == c[2] && c[1] == c[3]) || (c[4] == c[6] && c[5] == c[7]);
		sh1   = (c[0] == c[4] && c[1] == c[5]) || (c[0] == c[6] && c[1] == c[7]);
		sh2   = (c[2] == c[4] && c[3] == c[5]) || (c[2] == c[6] && c[3] == c[7]);
		meta_c1      = '0;
		meta_c1.px   = c[0];
		meta_c1.py   = c[1];
		meta_c1.kind = segisect_pkg::KIND_NONE;
		if (degen) begin
			meta_c1.done = 1'b1;
			meta_c1.kind = segisect_pkg::KIND_DEGEN;
		end else if (sh1) begin
			meta_c1.done = 1'b1;
			meta_c1.kind = segisect_pkg::KIND_SHARED;
			meta_c1.ex   = c[0];
			meta_c1.ey   = c[1];
		end else if (sh2) begin
			meta_c1.done = 1'b1;
			meta_c1.kind = segisect_pkg::KIND_SHARED;
			meta_c1.ex   = c[2];
			meta_c1.ey   = c[3];
		end
	end

	meta_t meta_s1;
	logic signed [DIFW-1:0] rx_s1, ry_s1, sx_s1, sy_s1, wx_s1, wy_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			meta_s1 <= meta_c1;
			rx_s1   <= {c[2][CW-1], c[2]} - {c[0][CW-1], c[0]};
			ry_s1   <= {c[3][CW-1], c[3]} - {c[1][CW-1], c[1]};
			sx_s1   <= {c[6][CW-1], c[6]} - {c[4][CW-1], c[4]};
			sy_s1   <= {c[7][CW-1], c[7]} - {c[5][CW-1], c[5]};
			wx_s1   <= {c[4][CW-1], c[4]} - {c[0][CW-1], c[0]};
			wy_s1   <= {c[5][CW-1], c[5]} - {c[1][CW-1], c[1]};
		end
	end

	// stage 2: partial products
	meta_t meta_s2;
	logic signed [DIFW-1:0] rx_s2, ry_s2;
	logic signed [PRW-1:0]  rxsy_s2, rysx_s2, wxsy_s2, wysx_s2, wxry_s2, wyrx_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			meta_s2 <= meta_s1;
			rx_s2   <= rx_s1;
			ry_s2   <= ry_s1;
			rxsy_s2 <= rx_s1 * sy_s1;
			rysx_s2 <= ry_s1 * sx_s1;
			wxsy_s2 <= wx_s1 * sy_s1;
			wysx_s2 <= wy_s1 * sx_s1;
			wxry_s2 <= wx_s1 * ry_s1;
			wyrx_s2 <= wy_s1 * rx_s1;
		end
	end

	// stage 3: cross products, normalized to positive denominator
	logic signed [XW-1:0] den_c3, tn_c3, un_c3;

	always_comb begin
		den_c3 = {rxsy_s2[PRW-1], rxsy_s2} - {rysx_s2[PRW-1], rysx_s2};
		tn_c3  = {wxsy_s2[PRW-1], wxsy_s2} - {wysx_s2[PRW-1], wysx_s2};
		un_c3  = {wxry_s2[PRW-1], wxry_s2} - {wyrx_s2[PRW-1], wyrx_s2};
		if (den_c3[XW-1]) begin
			den_c3 = -den_c3;
			tn_c3  = -tn_c3;
			un_c3  = -un_c3;
		end
	end

	meta_t meta_s3;
	logic signed [DIFW-1:0] rx_s3, ry_s3;
	logic [XW-1:0]          den_s3;
	logic signed [XW-1:0]   tn_s3, un_s3;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			meta_s3 <= meta_s2;
			rx_s3   <= rx_s2;
			ry_s3   <= ry_s2;
			den_s3  <= den_c3;
			tn_s3   <= tn_c3;
			un_s3   <= un_c3;
		end
	end

	// stage 4: tolerance product, parallel test, dividends
	logic [DIFW-1:0] arx_c4, ary_c4;
	logic [XW-1:0]   atn_c4;
	meta_t           meta_c4;

	always_comb begin
		arx_c4 = rx_s3[DIFW-1] ? DIFW'(-rx_s3) : DIFW'(rx_s3);
		ary_c4 = ry_s3[DIFW-1] ? DIFW'(-ry_s3) : DIFW'(ry_s3);
		atn_c4 = tn_s3[XW-1] ? XW'(-tn_s3) : XW'(tn_s3);
		meta_c4      = meta_s3;
		meta_c4.negx = rx_s3[DIFW-1] ^ tn_s3[XW-1];
		meta_c4.negy = ry_s3[DIFW-1] ^ tn_s3[XW-1];
	end

	meta_t meta_s4;
	logic [XW-1:0]        den_s4;
	logic signed [XW-1:0] tn_s4, un_s4;
	logic [EDW-1:0]       ed_s4;
	logic [NW-1:0]        nx_s4, ny_s4;
	logic                 par_s4;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			meta_s4 <= meta_c4;
			den_s4  <= den_s3;
			tn_s4   <= tn_s3;
			un_s4   <= un_s3;
			ed_s4   <= den_s3 * par_eps_q;
			nx_s4   <= arx_c4 * atn_c4;
			ny_s4   <= ary_c4 * atn_c4;
			par_s4  <= (den_s3 == '0) ||
				({{segisect_pkg::DEN_EPS_W{1'b0}}, den_s3} < {{XW{1'b0}}, den_eps_q});
		end
	end

	// stage 5: parameter range compare
	logic signed [CMPW-1:0] edw_c5, tw_c5, uw_c5, dw_c5;
	logic signed [CMPW-1:0] ta_c5, tb_c5, ua_c5, ub_c5;
	logic                   in_range_c5;
	meta_t                  meta_c5;

	always_comb begin
		edw_c5 = {{(CMPW-EDW){1'b0}}, ed_s4};
		tw_c5  = {{(CMPW-XW){tn_s4[XW-1]}}, tn_s4};
		uw_c5  = {{(CMPW-XW){un_s4[XW-1]}}, un_s4};
		dw_c5  = {{(CMPW-XW){1'b0}}, den_s4};
		ta_c5  = (tw_c5 <<< 16) + edw_c5;
		tb_c5  = ((dw_c5 - tw_c5) <<< 16) + edw_c5;
		ua_c5  = (uw_c5 <<< 16) + edw_c5;
		ub_c5  = ((dw_c5 - uw_c5) <<< 16) + edw_c5;
		in_range_c5 = !ta_c5[CMPW-1] && !tb_c5[CMPW-1] && !ua_c5[CMPW-1] && !ub_c5[CMPW-1];
		meta_c5 = meta_s4;
		if (!meta_s4.done) begin
			priority if (par_s4) begin
				meta_c5.kind = segisect_pkg::KIND_PARALLEL;
			end else if (in_range_c5) begin
				meta_c5.kind = segisect_pkg::KIND_CROSS;
			end else begin
				meta_c5.kind = segisect_pkg::KIND_NONE;
			end
		end
	end

	meta_t meta_s5;
	logic [XW-1:0] den_s5;
	logic [NW-1:0] nx_s5, ny_s5;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			meta_s5 <= meta_c5;
			den_s5  <= den_s4;
			nx_s5   <= nx_s4;
			ny_s5   <= ny_s4;
		end
	end

	// divider: one quotient bit per stage for both coordinates
	logic [RW-1:0] remx_sd [QW];
	logic [RW-1:0] remy_sd [QW];
	logic [QW-1:0] lowx_sd [QW];
	logic [QW-1:0] lowy_sd [QW];
	logic [XW-1:0] den_sd  [QW];
	meta_t         meta_sd [QW];

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [RW-1:0] rxi, ryi, tx, ty;
		logic [QW-1:0] lxi, lyi;
		logic [XW-1:0] di;
		meta_t         mi;
		logic          gx, gy;

		if (j == 0) begin : g_first
			assign rxi = RW'(nx_s5 >> QW);
			assign ryi = RW'(ny_s5 >> QW);
			assign lxi = nx_s5[QW-1:0];
			assign lyi = ny_s5[QW-1:0];
			assign di  = den_s5;
			assign mi  = meta_s5;
		end else begin : g_next
			assign rxi = remx_sd[j-1];
			assign ryi = remy_sd[j-1];
			assign lxi = lowx_sd[j-1];
			assign lyi = lowy_sd[j-1];
			assign di  = den_sd[j-1];
			assign mi  = meta_sd[j-1];
		end

		assign tx = {rxi[RW-2:0], lxi[QW-1]};
		assign ty = {ryi[RW-2:0], lyi[QW-1]};
		assign gx = tx >= RW'(di);
		assign gy = ty >= RW'(di);

		always_ff @(posedge clk) begin
			if (adv[FRONT+j]) begin
				remx_sd[j] <= gx ? tx - RW'(di) : tx;
				remy_sd[j] <= gy ? ty - RW'(di) : ty;
				lowx_sd[j] <= {lxi[QW-2:0], gx};
				lowy_sd[j] <= {lyi[QW-2:0], gy};
				den_sd[j]  <= di;
				meta_sd[j] <= mi;
			end
		end
	end

	// output stage: sign, offset, saturate
	meta_t                mo;
	logic signed [SW-1:0] sumx_c, sumy_c, satx_c, saty_c;
	logic [QW-1:0]        qx_c, qy_c;

	always_comb begin
		mo     = meta_sd[QW-1];
		qx_c   = lowx_sd[QW-1];
		qy_c   = lowy_sd[QW-1];
		sumx_c = {{(SW-CW){mo.px[CW-1]}}, mo.px} +
			(mo.negx ? -{2'b00, qx_c} : {2'b00, qx_c});
		sumy_c = {{(SW-CW){mo.py[CW-1]}}, mo.py} +
			(mo.negy ? -{2'b00, qy_c} : {2'b00, qy_c});
		satx_c = (sumx_c > CMAX) ? CMAX : ((sumx_c < CMIN) ? CMIN : sumx_c);
		saty_c = (sumy_c > CMAX) ? CMAX : ((sumy_c < CMIN) ? CMIN : sumy_c);
	end

	logic                          hit_so;
	segisect_pkg::kind_t           kind_so;
	logic [PW-1:0]                 cx_so, cy_so;

	always_ff @(posedge clk) begin
		if (adv[NS-1]) begin
			kind_so <= mo.kind;
			if (mo.kind == segisect_pkg::KIND_CROSS) begin
				hit_so <= 1'b1;
				cx_so  <= to_port(satx_c[CW-1:0]);
				cy_so  <= to_port(saty_c[CW-1:0]);
			end else begin
				hit_so <= (mo.kind == segisect_pkg::KIND_SHARED);
				cx_so  <= to_port(mo.ex);
				cy_so  <= to_port(mo.ey);
			end
		end
	end

	assign hit     = hit_so;
	assign kind    = kind_so;
	assign cross_x = cx_so;
	assign cross_y = cy_so;

	// checks
	a_hit_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |->
			(kind == segisect_pkg::KIND_SHARED || kind == segisect_pkg::KIND_CROSS))
		else $error("hit beat with a kind that is not a meeting");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> cross_x == '0 && cross_y == '0)
		else $error("miss beat with nonzero point");

	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");
endmodule
`default_nettype wire
